// File: hw/rtl/text_console_cursor_scroll_core_defines.svh
// ----------------------------------------------------------------------------
// text console core assertion macros
// concurrent assertion wrappers used by the console rtl, compiled out with
// NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CCS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("console assertion failed");
// next-cycle implication
`define CCS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("console assertion failed");
`else
`define CCS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CCS_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: hw/rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// shared types and constants of the text console cursor/scroll core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccs_pkg;

    // default screen store geometry
    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 128;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int RROW_W = 5;
    localparam int RCOL_W = 7;
    localparam int POS_W  = 12;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 8;
    localparam int CROWS_W = 6;
    localparam int CCOLS_W = 8;

    // new line codes
    localparam logic [CHAR_W-1:0] NL_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] CR_CODE = 8'd13;

    // register reset values
    localparam logic [CROWS_W-1:0] RST_ROWS = 6'd25;
    localparam logic [CCOLS_W-1:0] RST_COLS = 8'd80;
    localparam logic [ATTR_W-1:0]  RST_ATTR = 8'd10;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_ATTR = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_PUT = 2'd0,
        OP_BS  = 2'd1,
        OP_CLR = 2'd2,
        OP_RD  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LIMIT,
        ST_DISPATCH,
        ST_SC_RD,
        ST_SC_WR,
        ST_ZERO,
        ST_PUT_BODY,
        ST_NL_ADDR,
        ST_NL_WR,
        ST_CH_ADDR,
        ST_CH_WR,
        ST_BL_WR,
        ST_BS_ADDR,
        ST_BS_WR,
        ST_RD_MEM,
        ST_RD_DATA,
        ST_POS,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [CROWS_W-1:0] screen_rows;
        logic [CCOLS_W-1:0] screen_cols;
        logic [ATTR_W-1:0]  text_attr;
    } cfg_t;

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] ch;
    } cell_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              did_scroll;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
    } res_t;

endpackage

// File: hw/rtl/ccs_mac.sv
// ----------------------------------------------------------------------------
// ccs_mac
// shared multiply-add unit: prod = a * cols + b, registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccs_mac import ccs_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                                                aclk,
    input  logic                                                en,
    input  logic [$clog2(MAX_ROWS+1)-1:0]                       a,
    input  logic [$clog2(MAX_COLS+1)-1:0]                       b,
    input  logic [$clog2(MAX_COLS+1)-1:0]                       cols,
    output logic [$clog2(MAX_ROWS*MAX_COLS+MAX_COLS+1)-1:0]     prod
);

    localparam int RA = $clog2(MAX_ROWS + 1);
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int PW = $clog2(MAX_ROWS * MAX_COLS + MAX_COLS + 1);
    localparam int MW = RA + CW + 1;

    logic [MW-1:0] full;
    logic [PW-1:0] prod_reg;

    // row times pitch plus column
    assign full = MW'(a) * MW'(cols) + MW'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= full[PW-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

// File: hw/rtl/ccs_ram.sv
// ----------------------------------------------------------------------------
// ccs_ram
// character cell store, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccs_ram import ccs_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]  waddr,
    input  cell_t                                 wdata,
    input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]  raddr,
    output cell_t                                 rdata
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;

    cell_t cell_mem [DEPTH];
    cell_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            cell_mem[waddr] <= wdata;
        end
        rdata_reg <= cell_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/ccs_seq.sv
// ----------------------------------------------------------------------------
// ccs_seq
// operation sequencer: cursor state, scroll/clear sweeps, cell accesses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_cursor_scroll_core_defines.svh"

module ccs_seq import ccs_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   in_op,
    input  logic [CHAR_W-1:0] in_char,
    input  logic [RROW_W-1:0] in_row,
    input  logic [RCOL_W-1:0] in_col,
    input  logic              out_free,
    output logic              done,
    output res_t              res
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int RA    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int AW    = $clog2(MAX_ROWS * MAX_COLS);
    localparam int PW    = $clog2(MAX_ROWS * MAX_COLS + MAX_COLS + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    op_t               op_reg, op_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic [RROW_W-1:0] rr_reg, rr_next;
    logic [RCOL_W-1:0] rc_reg, rc_next;
    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic [CW-1:0]     cur_col_reg, cur_col_next;
    logic [PW-1:0]     limit_reg, limit_next;
    logic [PW-1:0]     scan_reg, scan_next;
    logic [PW-1:0]     zero_end_reg, zero_end_next;
    logic              scrolled_reg, scrolled_next;
    logic [CHAR_W-1:0] rchar_reg, rchar_next;
    logic [ATTR_W-1:0] rattr_reg, rattr_next;

    // shared unit and memory hookup
    logic          mac_en;
    logic [RA-1:0] mac_a;
    logic [CW-1:0] mac_b;
    logic [PW-1:0] mac_prod;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    cell_t         ram_wdata;
    logic [AW-1:0] ram_raddr;
    cell_t         ram_rdata;

    logic [8:0]    rows_w, rows_c, cols_w, cols_c;
    logic [RA-1:0] eff_rows;
    logic [CW-1:0] eff_cols;
    logic [RA-1:0] row_inc;
    logic [RA-1:0] row_t;
    logic [RW-1:0] last_row;
    logic          col_wrap;
    logic          newline;
    logic          rd_in_range;
    logic [PW-1:0] keep;
    logic [PW-1:0] scan_plus_cols;
    logic [PW+POS_W-1:0] pos_ext;
    logic [RW+ROW_W-1:0] row_ext;
    logic [CW+COL_W-1:0] col_ext;

    ccs_mac #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_mac (
        .aclk (aclk),
        .en   (mac_en),
        .a    (mac_a),
        .b    (mac_b),
        .cols (eff_cols),
        .prod (mac_prod)
    );

    ccs_ram #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // clamp screen geometry to the supported range
    assign rows_w = {3'b0, cfg.screen_rows};
    assign cols_w = {1'b0, cfg.screen_cols};

    always_comb begin
        if (rows_w == 9'd0) begin
            rows_c = 9'd1;
        end else if (rows_w > 9'(MAX_ROWS)) begin
            rows_c = 9'(MAX_ROWS);
        end else begin
            rows_c = rows_w;
        end
        if (cols_w < 9'd2) begin
            cols_c = 9'd2;
        end else if (cols_w > 9'(MAX_COLS)) begin
            cols_c = 9'(MAX_COLS);
        end else begin
            cols_c = cols_w;
        end
    end

    assign eff_rows = rows_c[RA-1:0];
    assign eff_cols = cols_c[CW-1:0];

    // cursor helpers
    assign row_inc  = RA'(cur_row_reg) + RA'(1);
    assign last_row = RW'(eff_rows - RA'(1));
    assign col_wrap = (cur_col_reg >= eff_cols);
    assign row_t    = col_wrap ? row_inc : RA'(cur_row_reg);
    assign newline  = (ch_reg == NL_CODE) || (ch_reg == CR_CODE);
    assign rd_in_range = ({4'b0, rr_reg} < rows_c) && ({2'b0, rc_reg} < cols_c);

    // scroll sweep bounds
    assign keep           = limit_reg - PW'(eff_cols);
    assign scan_plus_cols = scan_reg + PW'(eff_cols);

    // result fields, masked to port widths
    assign pos_ext = {{POS_W{1'b0}}, mac_prod};
    assign row_ext = {{ROW_W{1'b0}}, cur_row_reg};
    assign col_ext = {{COL_W{1'b0}}, cur_col_reg};

    always_comb begin
        res.cursor_pos = pos_ext[POS_W-1:0];
        res.cursor_row = row_ext[ROW_W-1:0];
        res.cursor_col = col_ext[COL_W-1:0];
        res.did_scroll = scrolled_reg;
        res.cell_char  = rchar_reg;
        res.cell_attr  = rattr_reg;
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ZERO;
        end else begin
            state_reg <= state_next;
        end
    end

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ret_reg      <= ST_IDLE;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            scan_reg     <= '0;
            zero_end_reg <= PW'(DEPTH);
            scrolled_reg <= 1'b0;
        end else begin
            ret_reg      <= ret_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            scan_reg     <= scan_next;
            zero_end_reg <= zero_end_next;
            scrolled_reg <= scrolled_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        ch_reg    <= ch_next;
        rr_reg    <= rr_next;
        rc_reg    <= rc_next;
        limit_reg <= limit_next;
        rchar_reg <= rchar_next;
        rattr_reg <= rattr_next;
    end

    // next state and outputs
    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        op_next       = op_reg;
        ch_next       = ch_reg;
        rr_next       = rr_reg;
        rc_next       = rc_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        limit_next    = limit_reg;
        scan_next     = scan_reg;
        zero_end_next = zero_end_reg;
        scrolled_next = scrolled_reg;
        rchar_next    = rchar_reg;
        rattr_next    = rattr_reg;
        in_ready      = 1'b0;
        done          = 1'b0;
        mac_en        = 1'b0;
        mac_a         = '0;
        mac_b         = '0;
        ram_we        = 1'b0;
        ram_waddr     = scan_reg[AW-1:0];
        ram_wdata     = '0;
        ram_raddr     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next       = op_t'(in_op);
                    ch_next       = in_char;
                    rr_next       = in_row;
                    rc_next       = in_col;
                    scrolled_next = 1'b0;
                    rchar_next    = '0;
                    rattr_next    = '0;
                    state_next    = ST_LIMIT;
                end
            end

            // cells in use = rows * cols
            ST_LIMIT: begin
                mac_en     = 1'b1;
                mac_a      = eff_rows;
                state_next = ST_DISPATCH;
            end

            ST_DISPATCH: begin
                limit_next = mac_prod;
                unique case (op_reg)
                    OP_PUT: begin
                        // wrap at right edge, scroll at bottom
                        if (row_t >= eff_rows) begin
                            scrolled_next = 1'b1;
                            cur_row_next  = last_row;
                            cur_col_next  = '0;
                            scan_next     = '0;
                            ret_next      = ST_PUT_BODY;
                            state_next    = ST_SC_RD;
                        end else begin
                            cur_row_next = RW'(row_t);
                            if (col_wrap) begin
                                cur_col_next = '0;
                            end
                            state_next = ST_PUT_BODY;
                        end
                    end
                    OP_BS: begin
                        if (cur_col_reg != '0) begin
                            cur_col_next = cur_col_reg - CW'(1);
                            state_next   = ST_BS_ADDR;
                        end else begin
                            state_next = ST_POS;
                        end
                    end
                    OP_CLR: begin
                        scan_next     = '0;
                        zero_end_next = mac_prod;
                        ret_next      = ST_POS;
                        state_next    = ST_ZERO;
                    end
                    OP_RD: begin
                        if (rd_in_range) begin
                            mac_en     = 1'b1;
                            mac_a      = RA'(rr_reg);
                            mac_b      = CW'(rc_reg);
                            state_next = ST_RD_MEM;
                        end else begin
                            state_next = ST_POS;
                        end
                    end
                endcase
            end

            // scroll: copy cell i + cols down to i
            ST_SC_RD: begin
                if (scan_reg < keep) begin
                    ram_raddr  = scan_plus_cols[AW-1:0];
                    state_next = ST_SC_WR;
                end else begin
                    zero_end_next = limit_reg;
                    state_next    = ST_ZERO;
                end
            end

            ST_SC_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = scan_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                scan_next  = scan_reg + PW'(1);
                state_next = ST_SC_RD;
            end

            // zero sweep up to zero_end, shared by scroll, clear and reset
            ST_ZERO: begin
                if (scan_reg < zero_end_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = scan_reg[AW-1:0];
                    scan_next = scan_reg + PW'(1);
                end else begin
                    state_next = ret_reg;
                end
            end

            ST_PUT_BODY: begin
                if (newline) begin
                    cur_col_next = '0;
                    if (row_inc >= eff_rows) begin
                        scrolled_next = 1'b1;
                        cur_row_next  = last_row;
                        scan_next     = '0;
                        ret_next      = ST_NL_ADDR;
                        state_next    = ST_SC_RD;
                    end else begin
                        cur_row_next = RW'(row_inc);
                        state_next   = ST_NL_ADDR;
                    end
                end else begin
                    state_next = ST_CH_ADDR;
                end
            end

            ST_NL_ADDR: begin
                mac_en     = 1'b1;
                mac_a      = RA'(cur_row_reg);
                state_next = ST_NL_WR;
            end

            ST_NL_WR: begin
                if (mac_prod < limit_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = mac_prod[AW-1:0];
                    ram_wdata = '{attr: cfg.text_attr, ch: '0};
                end
                state_next = ST_POS;
            end

            ST_CH_ADDR: begin
                mac_en     = 1'b1;
                mac_a      = RA'(cur_row_reg);
                mac_b      = cur_col_reg;
                state_next = ST_CH_WR;
            end

            // character, then blank at the following index
            ST_CH_WR: begin
                if (mac_prod < limit_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = mac_prod[AW-1:0];
                    ram_wdata = '{attr: cfg.text_attr, ch: ch_reg};
                end
                cur_col_next = cur_col_reg + CW'(1);
                scan_next    = mac_prod + PW'(1);
                state_next   = ST_BL_WR;
            end

            ST_BL_WR: begin
                if (scan_reg < limit_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = scan_reg[AW-1:0];
                    ram_wdata = '{attr: cfg.text_attr, ch: '0};
                end
                state_next = ST_POS;
            end

            ST_BS_ADDR: begin
                mac_en     = 1'b1;
                mac_a      = RA'(cur_row_reg);
                mac_b      = cur_col_reg;
                state_next = ST_BS_WR;
            end

            ST_BS_WR: begin
                if (mac_prod < limit_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = mac_prod[AW-1:0];
                    ram_wdata = '{attr: cfg.text_attr, ch: '0};
                end
                state_next = ST_POS;
            end

            ST_RD_MEM: begin
                ram_raddr  = mac_prod[AW-1:0];
                state_next = ST_RD_DATA;
            end

            ST_RD_DATA: begin
                rchar_next = ram_rdata.ch;
                rattr_next = ram_rdata.attr;
                state_next = ST_POS;
            end

            // linear cursor position for the result
            ST_POS: begin
                mac_en     = 1'b1;
                mac_a      = RA'(cur_row_reg);
                mac_b      = cur_col_reg;
                state_next = ST_OUT;
            end

            ST_OUT: begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // put-char leaves the cursor on screen, column at most the pitch
    `CCS_ASSERT_IMP(a_put_cursor_on_screen, aclk, aresetn,
        (state_reg == ST_OUT) && (op_reg == OP_PUT),
        (RA'(cur_row_reg) < eff_rows) && (cur_col_reg <= eff_cols))
    // only put-char can scroll
    `CCS_ASSERT_IMP(a_scroll_only_on_put, aclk, aresetn,
        done && res.did_scroll, op_reg == OP_PUT)
    // scroll copy source stays inside the cells in use
    `CCS_ASSERT_IMP(a_scroll_src_in_range, aclk, aresetn,
        (state_reg == ST_SC_RD) && (scan_reg < keep), scan_plus_cols < limit_reg)
    // one transaction at a time
    `CCS_ASSERT_NXT(a_busy_after_accept, aclk, aresetn,
        in_valid && in_ready, !in_ready)

endmodule

// File: hw/rtl/text_console_cursor_scroll_core.sv
// a backspace at column 0 or an out-of-range read skips the cell store access
// a scroll adds a copy sweep over (rows-1)*cols cells and a zero sweep over cols cells; a clear zeroes rows*cols cells
// one transaction at a time: s_ready returns in the same cycle that m_valid rises for the result
// after reset a clearing pass over all MAX_ROWS*MAX_COLS cells holds s_ready low
// synchronous active-low reset; registers reset to 25 rows, 80 cols, attr 10
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core
// text-mode console engine: cell store, cursor, scroll, clear and cell read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_scroll_core import ccs_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input transactions
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [CHAR_W-1:0] s_char_code,
    input  logic [RROW_W-1:0] s_read_row,
    input  logic [RCOL_W-1:0] s_read_col,
    // result transactions
    output logic              m_valid,
    input  logic              m_ready,
    output logic [POS_W-1:0]  m_cursor_pos,
    output logic [ROW_W-1:0]  m_cursor_row,
    output logic [COL_W-1:0]  m_cursor_col,
    output logic              m_did_scroll,
    output logic [CHAR_W-1:0] m_cell_char,
    output logic [ATTR_W-1:0] m_cell_attr,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t cfg_reg;
    logic cfg_wr;
    logic m_valid_reg;
    res_t res_reg;
    res_t seq_res;
    logic seq_done;
    logic out_free;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_rows <= RST_ROWS;
            cfg_reg.screen_cols <= RST_COLS;
            cfg_reg.text_attr   <= RST_ATTR;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ROWS: cfg_reg.screen_rows <= pwdata[CROWS_W-1:0];
                REG_COLS: cfg_reg.screen_cols <= pwdata[CCOLS_W-1:0];
                REG_ATTR: cfg_reg.text_attr   <= pwdata[ATTR_W-1:0];
                default:  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_ROWS: prdata = {{(32-CROWS_W){1'b0}}, cfg_reg.screen_rows};
            REG_COLS: prdata = {{(32-CCOLS_W){1'b0}}, cfg_reg.screen_cols};
            REG_ATTR: prdata = {{(32-ATTR_W){1'b0}}, cfg_reg.text_attr};
            default:  prdata = '0;
        endcase
    end

    ccs_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_op    (s_op),
        .in_char  (s_char_code),
        .in_row   (s_read_row),
        .in_col   (s_read_col),
        .out_free (out_free),
        .done     (seq_done),
        .res      (seq_res)
    );

    // result output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seq_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_done) begin
            res_reg <= seq_res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_pos = res_reg.cursor_pos;
    assign m_cursor_row = res_reg.cursor_row;
    assign m_cursor_col = res_reg.cursor_col;
    assign m_did_scroll = res_reg.did_scroll;
    assign m_cell_char  = res_reg.cell_char;
    assign m_cell_attr  = res_reg.cell_attr;

endmodule

// File: test/console_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// console_scoreboard_pkg
// cycle-free prediction of the text console core: cell store, cursor, scroll
// and clear, with an in-order compare of every status transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package console_scoreboard_pkg;

    import ccs_pkg::*;

    localparam int unsigned CELL_COUNT = DEF_MAX_ROWS * DEF_MAX_COLS;

    class console_scoreboard;

        // mirror of the screen and cursor
        cell_t       cell_mem [0:CELL_COUNT-1];
        int unsigned cursor_r;
        int unsigned cursor_c;

        // mirror of the register file
        logic [CROWS_W-1:0] rows_cfg;
        logic [CCOLS_W-1:0] cols_cfg;
        logic [ATTR_W-1:0]  attr_cfg;

        // status transactions still to come, oldest first
        res_t status_q [$];
        int   mismatches;

        function new();
            foreach (cell_mem[i]) cell_mem[i] = '0;
            cursor_r   = 0;
            cursor_c   = 0;
            rows_cfg   = RST_ROWS;
            cols_cfg   = RST_COLS;
            attr_cfg   = RST_ATTR;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_ROWS: rows_cfg = val[CROWS_W-1:0];
                REG_COLS: cols_cfg = val[CCOLS_W-1:0];
                REG_ATTR: attr_cfg = val[ATTR_W-1:0];
                default: ;
            endcase
        endfunction

        // size registers are used clamped to the store geometry
        function int unsigned used_rows();
            if (rows_cfg < 1) return 1;
            if (rows_cfg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
            return 32'(rows_cfg);
        endfunction

        function int unsigned used_cols();
            if (cols_cfg < 2) return 2;
            if (cols_cfg > DEF_MAX_COLS) return DEF_MAX_COLS;
            return 32'(cols_cfg);
        endfunction

        // writes outside the visible area are dropped
        function void store_cell(int unsigned idx, logic [CHAR_W-1:0] ch, int unsigned lim);
            if (idx < lim && idx < CELL_COUNT) begin
                cell_mem[idx].attr = attr_cfg;
                cell_mem[idx].ch   = ch;
            end
        endfunction

        // move every row up one, bottom row zeroed
        function void shift_up(int unsigned rows, int unsigned cols);
            int unsigned keep;
            keep = (rows - 1) * cols;
            for (int unsigned i = 0; i < keep; i++) cell_mem[i] = cell_mem[i + cols];
            for (int unsigned i = keep; i < rows * cols; i++) cell_mem[i] = '0;
        endfunction

        // accepted command: update the mirror and queue the status it yields
        function void apply_command(op_t op, logic [CHAR_W-1:0] ch,
                                    logic [RROW_W-1:0] rr, logic [RCOL_W-1:0] rc);
            int unsigned rows;
            int unsigned cols;
            int unsigned lim;
            res_t        r;
            rows = used_rows();
            cols = used_cols();
            lim  = rows * cols;
            r    = '0;
            case (op)
                OP_PUT: begin
                    // wrap at the right edge, scroll at the bottom
                    if (cursor_c >= cols) begin
                        cursor_r++;
                        cursor_c = 0;
                    end
                    if (cursor_r >= rows) begin
                        shift_up(rows, cols);
                        r.did_scroll = 1'b1;
                        cursor_r = rows - 1;
                        cursor_c = 0;
                    end
                    if (ch == NL_CODE || ch == CR_CODE) begin
                        cursor_r++;
                        cursor_c = 0;
                        if (cursor_r >= rows) begin
                            shift_up(rows, cols);
                            r.did_scroll = 1'b1;
                            cursor_r = rows - 1;
                        end
                        store_cell(cursor_r * cols, '0, lim);
                    end else begin
                        // character, then blank in the following cell
                        store_cell(cursor_r * cols + cursor_c, ch, lim);
                        cursor_c++;
                        store_cell(cursor_r * cols + cursor_c, '0, lim);
                    end
                end
                OP_BS: begin
                    if (cursor_c > 0) begin
                        cursor_c--;
                        store_cell(cursor_r * cols + cursor_c, '0, lim);
                    end
                end
                OP_CLR: begin
                    for (int unsigned i = 0; i < lim; i++) cell_mem[i] = '0;
                end
                default: begin
                    if (rr < rows && rc < cols) begin
                        r.cell_char = cell_mem[rr * cols + rc].ch;
                        r.cell_attr = cell_mem[rr * cols + rc].attr;
                    end
                end
            endcase
            r.cursor_pos = POS_W'(cursor_r * cols + cursor_c);
            r.cursor_row = ROW_W'(cursor_r);
            r.cursor_col = COL_W'(cursor_c);
            status_q.push_back(r);
        endfunction

        function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_status(res_t got);
            res_t want;
            if (status_q.size() == 0) begin
                $error("status transaction with none outstanding");
                mismatches++;
                return;
            end
            want = status_q.pop_front();
            cmp_field("cursor_pos", 32'(want.cursor_pos), 32'(got.cursor_pos));
            cmp_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
            cmp_field("cursor_col", 32'(want.cursor_col), 32'(got.cursor_col));
            cmp_field("did_scroll", 32'(want.did_scroll), 32'(got.did_scroll));
            cmp_field("cell_char", 32'(want.cell_char), 32'(got.cell_char));
            cmp_field("cell_attr", 32'(want.cell_attr), 32'(got.cell_attr));
        endfunction

        function int outstanding();
            return status_q.size();
        endfunction

    endclass

endpackage

// File: test/tb_text_console_cursor_scroll_core.sv
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll_core
// drives console commands with random idle gaps on both channels, walks the
// screen geometry through small, clamped and full-size settings, and checks
// every status transaction against the scoreboard in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll_core;

    import ccs_pkg::*;
    import console_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int          DRAIN_CYCLES = 40;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_op        = '0;
    logic [CHAR_W-1:0] s_char_code = '0;
    logic [RROW_W-1:0] s_read_row  = '0;
    logic [RCOL_W-1:0] s_read_col  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [POS_W-1:0]  m_cursor_pos;
    logic [ROW_W-1:0]  m_cursor_row;
    logic [COL_W-1:0]  m_cursor_col;
    logic              m_did_scroll;
    logic [CHAR_W-1:0] m_cell_char;
    logic [ATTR_W-1:0] m_cell_attr;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [3:0]        paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    console_scoreboard sb;
    int                tx_stretch = 0;
    int                rx_stretch = 0;
    int unsigned       cycle_count = 0;

    text_console_cursor_scroll_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_char_code  (s_char_code),
        .s_read_row   (s_read_row),
        .s_read_col   (s_read_col),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor_pos (m_cursor_pos),
        .m_cursor_row (m_cursor_row),
        .m_cursor_col (m_cursor_col),
        .m_did_scroll (m_did_scroll),
        .m_cell_char  (m_cell_char),
        .m_cell_attr  (m_cell_attr),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 aclk = ~aclk;

    // idle cycles before the next transaction, with runs of back-to-back ones
    function automatic int draw_wait(ref int stretch);
        if (stretch > 0) begin
            stretch--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            stretch = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // register write: setup cycle, access cycle, then psel dropped to idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // one command transaction; valid stays high across back-to-back items
    task automatic send_item(input op_t op, input logic [CHAR_W-1:0] ch,
                             input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc);
        int gap;
        gap = draw_wait(tx_stretch);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_char_code <= ch;
        s_read_row  <= rr;
        s_read_col  <= rc;
        do @(posedge aclk); while (!s_ready);
        sb.apply_command(op, ch, rr, rc);
    endtask

    task automatic wait_idle();
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    // new geometry and attribute, then a random command stream
    task automatic run_phase(input int rows, input int cols, input int attr, input int n,
                             input int nl_pct, input int clr_pct);
        int                pick;
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [RROW_W-1:0] rr;
        logic [RCOL_W-1:0] rc;
        wait_idle();
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
        write_reg(REG_ATTR, attr);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < clr_pct) op = OP_CLR;
            else if (pick < clr_pct + 10) op = OP_BS;
            else if (pick < clr_pct + 35) op = OP_RD;
            else op = OP_PUT;
            ch = CHAR_W'($urandom_range(0, 255));
            if (op == OP_PUT && $urandom_range(0, 99) < nl_pct)
                ch = $urandom_range(0, 1) ? NL_CODE : CR_CODE;
            // reads mostly land inside the visible area
            if ($urandom_range(0, 9) < 7) begin
                rr = RROW_W'($urandom_range(0, sb.used_rows() - 1));
                rc = RCOL_W'($urandom_range(0, sb.used_cols() - 1));
            end else begin
                rr = RROW_W'($urandom);
                rc = RCOL_W'($urandom);
            end
            send_item(op, ch, rr, rc);
        end
        s_valid <= 1'b0;
    endtask

    // result channel back-pressure
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = draw_wait(rx_stretch);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // status transaction monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_status({m_cursor_pos, m_cursor_row, m_cursor_col, m_did_scroll,
                             m_cell_char, m_cell_attr});
    end

    // run time guard
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // default geometry: field extremes, a new line, backspace, clear
        send_item(OP_RD, 8'h00, 5'd0, 7'd0);
        send_item(OP_PUT, 8'h41, 5'd0, 7'd0);
        send_item(OP_PUT, 8'hFF, 5'd31, 7'd127);
        send_item(OP_PUT, 8'h00, 5'd0, 7'd0);
        send_item(OP_PUT, NL_CODE, 5'd0, 7'd0);
        send_item(OP_BS, 8'h00, 5'd0, 7'd0);
        send_item(OP_PUT, 8'h42, 5'd0, 7'd0);
        send_item(OP_BS, 8'hFF, 5'd31, 7'd127);
        send_item(OP_RD, 8'h00, 5'd0, 7'd1);
        send_item(OP_RD, 8'h00, 5'd31, 7'd127);
        send_item(OP_CLR, 8'h00, 5'd0, 7'd0);
        send_item(OP_RD, 8'h00, 5'd0, 7'd0);
        s_valid <= 1'b0;

        // tiny screen: wrap, blank past the last cell, scroll, new line at bottom
        run_phase(2, 3, 90, 0, 0, 0);
        send_item(OP_PUT, 8'h61, 5'd0, 7'd0);
        send_item(OP_PUT, 8'h62, 5'd0, 7'd0);
        send_item(OP_PUT, 8'h63, 5'd0, 7'd0);
        send_item(OP_PUT, 8'h64, 5'd0, 7'd0);
        send_item(OP_PUT, 8'h65, 5'd0, 7'd0);
        send_item(OP_PUT, 8'h66, 5'd0, 7'd0);
        send_item(OP_PUT, 8'h67, 5'd0, 7'd0);
        send_item(OP_PUT, CR_CODE, 5'd0, 7'd0);
        send_item(OP_RD, 8'h00, 5'd0, 7'd0);
        send_item(OP_RD, 8'h00, 5'd1, 7'd2);
        send_item(OP_RD, 8'h00, 5'd2, 7'd0);
        send_item(OP_BS, 8'h00, 5'd0, 7'd0);
        s_valid <= 1'b0;

        // single row and clamped-low sizes
        run_phase(1, 2, 0, 100, 20, 5);
        run_phase(0, 1, 255, 60, 20, 5);
        run_phase(4, 8, $urandom_range(0, 255), 100, 15, 4);
        repeat (4)
            run_phase($urandom_range(1, 8), $urandom_range(2, 16),
                      $urandom_range(0, 255), 100, 12, 3);
        // full size, then shrink so the cursor sits outside the screen
        run_phase(32, 128, 255, 40, 40, 2);
        run_phase(3, 5, $urandom_range(0, 255), 100, 15, 4);
        // clamped-high sizes, then shrink again
        run_phase(63, 255, 128, 40, 50, 2);
        run_phase(2, 7, $urandom_range(0, 255), 100, 15, 4);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ccs_pkg.sv
hw/rtl/ccs_mac.sv
hw/rtl/ccs_ram.sv
hw/rtl/ccs_seq.sv
hw/rtl/text_console_cursor_scroll_core.sv
test/console_scoreboard_pkg.sv
test/tb_text_console_cursor_scroll_core.sv
